// ----- hdl/sample_time_sync_interpolator_assert.svh -----
// assertion macros for the sample time sync interpolator
`ifndef SAMPLE_TIME_SYNC_INTERPOLATOR_ASSERT_SVH
`define SAMPLE_TIME_SYNC_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define STSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stsi assertion failed");

// next-cycle implication
`define STSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stsi assertion failed");

`endif

// ----- hdl/stsi_pkg.sv -----
// package with sample record, field widths and sequencer states
`default_nettype none
package stsi_pkg;

    localparam int TIME_W = 48;
    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int ALT_W  = 32;
    localparam int FIX_W  = 3;
    localparam int GAP_W  = 24;
    localparam int W_W    = 32;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 152;
    localparam int IN_PAD_W   = IN_DATA_W - (2 * TIME_W + LAT_W + LON_W + ALT_W + FIX_W);
    localparam int OUT_PAD_W  = OUT_DATA_W - (TIME_W + LAT_W + LON_W + ALT_W + FIX_W);

    localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    typedef struct packed {
        logic        [FIX_W-1:0]  fix;
        logic signed [ALT_W-1:0]  alt;
        logic signed [LON_W-1:0]  lon;
        logic signed [LAT_W-1:0]  lat;
        logic        [TIME_W-1:0] tstamp;
    } sample_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD0  = 9'b000000010,
        S_RD1  = 9'b000000100,
        S_CMP  = 9'b000001000,
        S_DIVI = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_RND  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        SEL_LAT = 2'd0,
        SEL_LON = 2'd1,
        SEL_ALT = 2'd2
    } sel_t;

endpackage
`default_nettype wire

// ----- hdl/sample_time_sync_interpolator.sv -----
// A push item (tuser 0) stores a timestamped position sample in a circular queue, the oldest
// sample overwritten when full. A sync item (tuser 1) scans the queue front: each front pair
// takes two reads of the sample memory and one compare, then one restoring divider produces
// the weight and one shared multiplier blends latitude, longitude and altitude in turn, so a
// sync item holds the input until it is done; the divider is skipped when the weight
// saturates, and a sync with fewer than two samples goes straight to the output. The result
// waits in an output register while the next item is taken; a further result waits until
// that register has been read.
`default_nettype none
`include "sample_time_sync_interpolator_assert.svh"
module sample_time_sync_interpolator #(
    parameter int QUEUE_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // sample_time, sample_lat, sample_lon, sample_alt, sample_fix_status, request_time, pad
    input  wire  [stsi_pkg::IN_DATA_W-1:0]  s_tdata,
    // command
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // out_time, out_lat, out_lon, out_alt, out_fix_status, pad
    output logic [stsi_pkg::OUT_DATA_W-1:0] m_tdata,
    // found
    output logic                            m_tuser,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [stsi_pkg::GAP_W-1:0]      cfg_data
);

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = AW + 1;
    localparam int TW  = stsi_pkg::TIME_W;
    localparam int NW  = TW + FRAC_BITS;
    localparam int DW  = TW + 31;
    localparam int QW  = 31;
    localparam int KW  = 5;
    localparam int PW  = 64;
    localparam int VW  = 66;

    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] TWO_CNT   = CW'(2);
    localparam logic [QW-1:0] W_LIMIT   = QW'(1) << 30;
    localparam logic signed [VW-1:0] LAT_MAX = (VW'(1) << (stsi_pkg::LAT_W - 1)) - VW'(1);
    localparam logic signed [VW-1:0] WID_MAX = (VW'(1) << (stsi_pkg::LON_W - 1)) - VW'(1);

    stsi_pkg::sample_t mem [QUEUE_DEPTH];
    stsi_pkg::sample_t rd_data_reg;
    stsi_pkg::sample_t s0_reg, s0_next;

    stsi_pkg::state_t state_reg, state_next;
    stsi_pkg::sel_t   sel_reg, sel_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [stsi_pkg::GAP_W-1:0] gap_reg, gap_next;
    logic             final_reg, final_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [TW-1:0]    target_reg, target_next;
    logic [TW-1:0]    nmag_reg, nmag_next;
    logic [TW-1:0]    dmag_reg, dmag_next;
    logic             neg_reg, neg_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dsh_reg, dsh_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [KW-1:0]    k_reg, k_next;
    logic signed [stsi_pkg::W_W-1:0] w_reg, w_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic             res_found_reg, res_found_next;
    logic signed [stsi_pkg::LAT_W-1:0] res_lat_reg, res_lat_next;
    logic signed [stsi_pkg::LON_W-1:0] res_lon_reg, res_lon_next;
    logic signed [stsi_pkg::ALT_W-1:0] res_alt_reg, res_alt_next;
    logic [stsi_pkg::FIX_W-1:0] res_fix_reg, res_fix_next;
    logic [stsi_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    stsi_pkg::sample_t wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    head_inc;
    logic [SW-1:0]    push_sum;
    logic             in_acc;
    logic [TW-1:0]    t0, t1;
    logic signed [TW:0] num_s, den_s;
    logic [DW-1:0]    rem_ext;
    logic [DW-1:0]    sat_lim;
    logic [QW-1:0]    q_fin;
    logic [QW-1:0]    mag;
    logic signed [32:0] a0_ext, a1_ext, diff;
    logic [PW-1:0]    pabs, mrnd;
    logic signed [VW-1:0] v, vmax, vsat;

    assign s_tready  = (state_reg == stsi_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign in_acc    = s_tvalid && s_tready;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign push_sum = SW'(head_reg) + SW'(count_reg);
    assign t0       = s0_reg.tstamp;
    assign t1       = rd_data_reg.tstamp;
    assign num_s    = $signed({1'b0, target_reg}) - $signed({1'b0, t0});
    assign den_s    = $signed({1'b0, t1}) - $signed({1'b0, t0});
    assign rem_ext  = DW'(rem_reg);
    assign sat_lim  = DW'(dmag_reg) << (31 - FRAC_BITS);

    always_comb
    begin
        wr_data.tstamp = s_tdata[47:0];
        wr_data.lat    = s_tdata[78:48];
        wr_data.lon    = s_tdata[110:79];
        wr_data.alt    = s_tdata[142:111];
        wr_data.fix    = s_tdata[145:143];
        wr_en          = in_acc && (s_tuser == stsi_pkg::CMD_PUSH);
        if (count_reg == FULL_CNT)
        begin
            wr_addr = head_reg;
        end
        else if (push_sum >= SW'(QUEUE_DEPTH))
        begin
            wr_addr = AW'(push_sum - SW'(QUEUE_DEPTH));
        end
        else
        begin
            wr_addr = AW'(push_sum);
        end
        rd_en   = (state_reg == stsi_pkg::S_RD0) || (state_reg == stsi_pkg::S_RD1);
        rd_addr = (state_reg == stsi_pkg::S_RD0) ? head_reg : head_inc;
    end

    always_comb
    begin
        case (sel_reg)
            stsi_pkg::SEL_LAT:
            begin
                a0_ext = 33'(s0_reg.lat);
                a1_ext = 33'(rd_data_reg.lat);
                vmax   = LAT_MAX;
            end
            stsi_pkg::SEL_LON:
            begin
                a0_ext = 33'(s0_reg.lon);
                a1_ext = 33'(rd_data_reg.lon);
                vmax   = WID_MAX;
            end
            default:
            begin
                a0_ext = 33'(s0_reg.alt);
                a1_ext = 33'(rd_data_reg.alt);
                vmax   = WID_MAX;
            end
        endcase
        diff = a1_ext - a0_ext;
        pabs = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        mrnd = (pabs + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        v    = prod_reg[PW-1] ? VW'(a0_ext) - $signed(VW'(mrnd))
                              : VW'(a0_ext) + $signed(VW'(mrnd));
        if (v > vmax)
        begin
            vsat = vmax;
        end
        else if (v < -vmax - VW'(1))
        begin
            vsat = -vmax - VW'(1);
        end
        else
        begin
            vsat = v;
        end
        q_fin = {q_reg[QW-2:0], (rem_ext >= dsh_reg)};
        mag   = (q_fin > W_LIMIT) ? W_LIMIT : q_fin;
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        gap_next       = gap_reg;
        final_next     = final_reg;
        m_tvalid_next  = m_tvalid_reg;
        target_next    = target_reg;
        s0_next        = s0_reg;
        nmag_next      = nmag_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        prod_next      = prod_reg;
        res_found_next = res_found_reg;
        res_lat_next   = res_lat_reg;
        res_lon_next   = res_lon_reg;
        res_alt_next   = res_alt_reg;
        res_fix_next   = res_fix_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_valid && cfg_ready)
        begin
            gap_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            stsi_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == stsi_pkg::CMD_PUSH)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            head_next = head_inc;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        target_next    = s_tdata[193:146];
                        final_next     = 1'b0;
                        res_found_next = 1'b0;
                        res_lat_next   = '0;
                        res_lon_next   = '0;
                        res_alt_next   = '0;
                        res_fix_next   = '0;
                        state_next     = (count_reg < TWO_CNT) ? stsi_pkg::S_OUT
                                                               : stsi_pkg::S_RD0;
                    end
                end
            end
            stsi_pkg::S_RD0:
            begin
                state_next = stsi_pkg::S_RD1;
            end
            stsi_pkg::S_RD1:
            begin
                s0_next    = rd_data_reg;
                state_next = stsi_pkg::S_CMP;
            end
            stsi_pkg::S_CMP:
            begin
                nmag_next = num_s[TW] ? TW'(-num_s) : TW'(num_s);
                dmag_next = den_s[TW] ? TW'(-den_s) : TW'(den_s);
                neg_next  = num_s[TW] ^ den_s[TW];
                if (final_reg)
                begin
                    state_next = (t1 == t0) ? stsi_pkg::S_OUT : stsi_pkg::S_DIVI;
                end
                else if (t0 > target_reg)
                begin
                    state_next = stsi_pkg::S_OUT;
                end
                else if ((t1 < target_reg) || (target_reg - t0 > TW'(gap_reg))
                         || (t1 - target_reg > TW'(gap_reg)))
                begin
                    final_next = !(t1 < target_reg);
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                    state_next = (count_reg - CW'(1) < TWO_CNT) ? stsi_pkg::S_OUT
                                                                : stsi_pkg::S_RD0;
                end
                else
                begin
                    state_next = (t1 == t0) ? stsi_pkg::S_OUT : stsi_pkg::S_DIVI;
                end
            end
            stsi_pkg::S_DIVI:
            begin
                sel_next = stsi_pkg::SEL_LAT;
                if (DW'(nmag_reg) >= sat_lim)
                begin
                    w_next     = neg_reg ? -(stsi_pkg::W_W'(W_LIMIT))
                                         : stsi_pkg::W_W'(W_LIMIT);
                    state_next = stsi_pkg::S_MUL;
                end
                else
                begin
                    rem_next   = NW'(nmag_reg) << FRAC_BITS;
                    dsh_next   = DW'(dmag_reg) << 30;
                    q_next     = '0;
                    k_next     = KW'(30);
                    state_next = stsi_pkg::S_DIV;
                end
            end
            stsi_pkg::S_DIV:
            begin
                if (rem_ext >= dsh_reg)
                begin
                    rem_next = NW'(rem_ext - dsh_reg);
                end
                q_next   = q_fin;
                dsh_next = dsh_reg >> 1;
                k_next   = k_reg - KW'(1);
                if (k_reg == '0)
                begin
                    w_next     = neg_reg ? -(stsi_pkg::W_W'(mag)) : stsi_pkg::W_W'(mag);
                    state_next = stsi_pkg::S_MUL;
                end
            end
            stsi_pkg::S_MUL:
            begin
                prod_next  = PW'(diff) * PW'(w_reg);
                state_next = stsi_pkg::S_RND;
            end
            stsi_pkg::S_RND:
            begin
                case (sel_reg)
                    stsi_pkg::SEL_LAT:
                    begin
                        res_lat_next = stsi_pkg::LAT_W'(vsat);
                        sel_next     = stsi_pkg::SEL_LON;
                        state_next   = stsi_pkg::S_MUL;
                    end
                    stsi_pkg::SEL_LON:
                    begin
                        res_lon_next = stsi_pkg::LON_W'(vsat);
                        sel_next     = stsi_pkg::SEL_ALT;
                        state_next   = stsi_pkg::S_MUL;
                    end
                    default:
                    begin
                        res_alt_next   = stsi_pkg::ALT_W'(vsat);
                        res_fix_next   = rd_data_reg.fix;
                        res_found_next = 1'b1;
                        state_next     = stsi_pkg::S_OUT;
                    end
                endcase
            end
            stsi_pkg::S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_found_reg;
                    m_tdata_next  = {{stsi_pkg::OUT_PAD_W{1'b0}}, res_fix_reg, res_alt_reg,
                                     res_lon_reg, res_lat_reg, target_reg};
                    state_next    = stsi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stsi_pkg::S_IDLE;
            end
        endcase
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stsi_pkg::S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            gap_reg      <= stsi_pkg::GAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            gap_reg      <= gap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg       <= sel_next;
        final_reg     <= final_next;
        target_reg    <= target_next;
        s0_reg        <= s0_next;
        nmag_reg      <= nmag_next;
        dmag_reg      <= dmag_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        k_reg         <= k_next;
        w_reg         <= w_next;
        prod_reg      <= prod_next;
        res_found_reg <= res_found_next;
        res_lat_reg   <= res_lat_next;
        res_lon_reg   <= res_lon_next;
        res_alt_reg   <= res_alt_next;
        res_fix_reg   <= res_fix_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    `STSI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `STSI_ASSERT_NEXT(a_push_grows, clk, rst_n, wr_en && (count_reg != FULL_CNT),
                      count_reg == $past(count_reg) + CW'(1))
    `STSI_ASSERT_NOW(a_result_from_out, clk, rst_n, $rose(m_tvalid_reg), $past(state_reg == stsi_pkg::S_OUT))

endmodule
`default_nettype wire

// ----- dv/tb_sample_time_sync_interpolator.sv -----
// testbench for sample_time_sync_interpolator: directed table and random streams vs a predictor
`default_nettype none
module tb_sample_time_sync_interpolator;

    localparam int DEPTH     = 16;
    localparam int FRAC      = 16;
    localparam int DOG_LIMIT = 20000;
    localparam int SETTLE    = 200;
    localparam int EXP_DEPTH = 64;
    localparam int DIR_MAX   = 32;

    typedef struct {
        logic                        cmd;
        logic [stsi_pkg::TIME_W-1:0] t;
        logic [stsi_pkg::LAT_W-1:0]  lat;
        logic [stsi_pkg::LON_W-1:0]  lon;
        logic [stsi_pkg::ALT_W-1:0]  alt;
        logic [stsi_pkg::FIX_W-1:0]  fix;
        logic [stsi_pkg::TIME_W-1:0] req;
    } sample_item_t;

    typedef struct {
        logic                        found;
        logic [stsi_pkg::TIME_W-1:0] t;
        logic [stsi_pkg::LAT_W-1:0]  lat;
        logic [stsi_pkg::LON_W-1:0]  lon;
        logic [stsi_pkg::ALT_W-1:0]  alt;
        logic [stsi_pkg::FIX_W-1:0]  fix;
    } fix_result_t;

    typedef struct {
        sample_item_t item;
        bit           typed;
        fix_result_t  res;
    } table_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [stsi_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [stsi_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [stsi_pkg::GAP_W-1:0]      cfg_data = '0;

    sample_time_sync_interpolator #(.QUEUE_DEPTH(DEPTH), .FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [stsi_pkg::TIME_W-1:0] pq_time [DEPTH];
    longint                      pq_lat  [DEPTH];
    longint                      pq_lon  [DEPTH];
    longint                      pq_alt  [DEPTH];
    logic [stsi_pkg::FIX_W-1:0]  pq_fix  [DEPTH];
    int                          pq_head = 0;
    int                          pq_count = 0;
    longint                      gap_limit = 200000;

    // expected results in arrival order
    fix_result_t exp_ring [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;

    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;
    logic [stsi_pkg::TIME_W-1:0] tcur = '0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void exp_put(fix_result_t r);
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic int exp_pending();
        return exp_wr - exp_rd;
    endfunction

    function automatic fix_result_t exp_take();
        fix_result_t r;
        r = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        return r;
    endfunction

    function automatic void drop_front();
        if (pq_count > 0)
        begin
            pq_head = (pq_head + 1) % DEPTH;
            pq_count--;
        end
    endfunction

    function automatic longint sync_weight(longint num, longint den);
        bit          neg;
        logic [63:0] n, d, q, r, frac, mag;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q >= (64'd1 << (30 - FRAC)))
            mag = 64'd1 << 30;
        else
        begin
            frac = '0;
            for (int i = 0; i < FRAC; i++)
            begin
                r = r << 1;
                frac = frac << 1;
                if (r >= d)
                begin
                    r = r - d;
                    frac = frac | 64'd1;
                end
            end
            mag = (q << FRAC) | frac;
            if (mag > (64'd1 << 30))
                mag = 64'd1 << 30;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint blend_value(longint a0, longint a1, longint w, int width);
        longint      p, v, hi, lo;
        logic [63:0] m;
        p = (a1 - a0) * w;
        m = p < 0 ? -p : p;
        hi = (longint'(1) <<< (width - 1)) - 1;
        lo = -hi - 1;
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        v = a0 + (p < 0 ? -longint'(m) : longint'(m));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic void interp_predict(sample_item_t it);
        fix_result_t res;
        longint      target, t0, t1, w;
        int          s0, s1, s;
        bit          ok;
        if (it.cmd == stsi_pkg::CMD_PUSH)
        begin
            if (pq_count >= DEPTH)
                drop_front();
            s = (pq_head + pq_count) % DEPTH;
            pq_time[s] = it.t;
            pq_lat[s] = longint'($signed(it.lat));
            pq_lon[s] = longint'($signed(it.lon));
            pq_alt[s] = longint'($signed(it.alt));
            pq_fix[s] = it.fix;
            pq_count++;
            return;
        end
        ok = 1;
        target = longint'({16'd0, it.req});
        while (pq_count >= 2)
        begin
            t0 = longint'({16'd0, pq_time[pq_head]});
            t1 = longint'({16'd0, pq_time[(pq_head + 1) % DEPTH]});
            if (t0 > target)
            begin
                ok = 0;
                break;
            end
            if (t1 < target)
            begin
                drop_front();
                continue;
            end
            if (target - t0 > gap_limit || t1 - target > gap_limit)
                drop_front();
            break;
        end
        if (pq_count < 2)
            ok = 0;
        res = '{found: 1'b0, t: it.req, lat: '0, lon: '0, alt: '0, fix: '0};
        if (ok)
        begin
            s0 = pq_head;
            s1 = (pq_head + 1) % DEPTH;
            t0 = longint'({16'd0, pq_time[s0]});
            t1 = longint'({16'd0, pq_time[s1]});
            if (t1 != t0)
            begin
                w = sync_weight(target - t0, t1 - t0);
                res.found = 1'b1;
                res.lat = stsi_pkg::LAT_W'(blend_value(pq_lat[s0], pq_lat[s1], w,
                                                        stsi_pkg::LAT_W));
                res.lon = stsi_pkg::LON_W'(blend_value(pq_lon[s0], pq_lon[s1], w,
                                                        stsi_pkg::LON_W));
                res.alt = stsi_pkg::ALT_W'(blend_value(pq_alt[s0], pq_alt[s1], w,
                                                        stsi_pkg::ALT_W));
                res.fix = pq_fix[s1];
            end
        end
        exp_put(res);
    endfunction

    // result side: stalls, long hold-off and field checks
    always @(posedge clk)
    begin
        fix_result_t want;
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_pending() == 0)
                report_mismatch("unexpected result", 64'(m_tdata[stsi_pkg::TIME_W-1:0]),
                                64'd0);
            else
            begin
                want = exp_take();
                if (m_tuser !== want.found)
                    report_mismatch("found", 64'(m_tuser), 64'(want.found));
                if (m_tdata[47:0] !== want.t)
                    report_mismatch("out_time", 64'(m_tdata[47:0]), 64'(want.t));
                if (m_tdata[78:48] !== want.lat)
                    report_mismatch("out_lat", 64'(m_tdata[78:48]), 64'(want.lat));
                if (m_tdata[110:79] !== want.lon)
                    report_mismatch("out_lon", 64'(m_tdata[110:79]), 64'(want.lon));
                if (m_tdata[142:111] !== want.alt)
                    report_mismatch("out_alt", 64'(m_tdata[142:111]), 64'(want.alt));
                if (m_tdata[145:143] !== want.fix)
                    report_mismatch("out_fix_status", 64'(m_tdata[145:143]), 64'(want.fix));
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT)
        begin
            $display("sample_time_sync_interpolator verification failed");
            $finish;
        end
    end

    task automatic send_item(sample_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {{stsi_pkg::IN_PAD_W{1'b0}}, it.req, it.fix, it.alt, it.lon, it.lat, it.t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        interp_predict(it);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (exp_pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gap(logic [stsi_pkg::GAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gap_limit = longint'(v);
    endtask

    function automatic sample_item_t rand_item();
        sample_item_t it;
        int           r;
        longint       span, back;
        r = $urandom_range(99);
        it.cmd = 1'($urandom_range(1));
        it.t = stsi_pkg::TIME_W'({$urandom, $urandom});
        it.req = stsi_pkg::TIME_W'({$urandom, $urandom});
        it.fix = stsi_pkg::FIX_W'($urandom);
        if ($urandom_range(1))
        begin
            it.lat = stsi_pkg::LAT_W'($urandom);
            it.lon = $urandom;
            it.alt = $urandom;
        end
        else
        begin
            it.lat = stsi_pkg::LAT_W'($urandom_range(1800000000) - 900000000);
            it.lon = $urandom_range(1800000000) - 900000000;
            it.alt = $urandom_range(2000000) - 1000000;
        end
        if (r < 10)
            return it;
        span = gap_limit + gap_limit / 2 + 1000;
        if (r < 65)
        begin
            it.cmd = stsi_pkg::CMD_PUSH;
            if ($urandom_range(19) != 0)
                tcur = tcur + $urandom_range(32'(span), 1);
            it.t = tcur;
        end
        else
        begin
            it.cmd = stsi_pkg::CMD_SYNC;
            back = $urandom_range(32'(2 * span), 0);
            it.req = (longint'({16'd0, tcur}) > back) ? stsi_pkg::TIME_W'(tcur - back) : '0;
        end
        return it;
    endfunction

    function automatic table_row_t row(logic cmd, longint t, longint lat, longint lon,
                                       longint alt, longint fix, longint req, bit typed,
                                       logic found, longint elat, longint elon,
                                       longint ealt, longint efix);
        row.item = '{cmd, stsi_pkg::TIME_W'(t), stsi_pkg::LAT_W'(lat), stsi_pkg::LON_W'(lon),
                     stsi_pkg::ALT_W'(alt), stsi_pkg::FIX_W'(fix), stsi_pkg::TIME_W'(req)};
        row.typed = typed;
        row.res = '{found, stsi_pkg::TIME_W'(req), stsi_pkg::LAT_W'(elat),
                    stsi_pkg::LON_W'(elon), stsi_pkg::ALT_W'(ealt), stsi_pkg::FIX_W'(efix)};
    endfunction

    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

    table_row_t   directed [DIR_MAX];
    int           n_rows = 0;
    sample_item_t it;

    function automatic void add_row(table_row_t r);
        directed[n_rows] = r;
        n_rows++;
    endfunction

    initial
    begin
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, TMAX, '1, '1, '1, '1, TMAX, 1, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, 1000, 900000000, -1800000000, 32'h7FFF_FFFF,
                    3'b111, TMAX, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 1000, 1, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, 101000, -900000000, 1800000000, 32'h8000_0000,
                    3'd2, 0, 0, 0, 0, 0, 0, 0));
        // front sample later than the target
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 500, 1, 0, 0, 0, 0, 0));
        // target on the front sample gives its position, with the fix status of the next sample
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 1000, 1, 1, 900000000,
                    -1800000000, 32'h7FFF_FFFF, 3'd2));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 51000, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, 101000, 0, 0, 0, 3'd1, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 101000, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 101001, 1, 0, 0, 0, 0, 0));
        // equal times
        add_row(row(stsi_pkg::CMD_PUSH, 101000, 5, 5, 5, 3'd0, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 101000, 1, 0, 0, 0, 0, 0));
        // gap too wide
        add_row(row(stsi_pkg::CMD_PUSH, 900000, 7, -7, 7, 3'd1, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 800000, 1, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, 1000000, 100, 200, 300, 3'd2, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, 1100000, -100, -200, -300, 3'b111, 0, 0, 0, 0, 0,
                    0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, 1033333, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, TMAX - 1, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    3'b100, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_PUSH, TMAX, 31'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    3'b011, 0, 0, 0, 0, 0, 0, 0));
        add_row(row(stsi_pkg::CMD_SYNC, 0, 0, 0, 0, 0, TMAX, 0, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < n_rows; i++)
        begin
            send_item(directed[i].item);
            if (directed[i].typed)
                exp_ring[(exp_wr - 1) % EXP_DEPTH] = directed[i].res;
        end
        drain_results();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_gap(24'd0);
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    write_gap(24'd10000000);
                    idle_pct = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    write_gap(24'd200000);
                    idle_pct = 0;
                    stall_pct = 57;
                end
                3:
                begin
                    write_gap(stsi_pkg::GAP_W'($urandom_range(400000)));
                    idle_pct = 18;
                    stall_pct = 18;
                end
                4:
                begin
                    write_gap(24'd1);
                    idle_pct = 0;
                    stall_pct = 0;
                end
                default:
                begin
                    write_gap(24'd150000);
                    idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            tcur = (ph == 1) ? TMAX - 48'd400000000
                             : {16'($urandom_range(255)), 32'd0};
            if (ph == 5)
                hold_cycles = 3000;
            for (int n = 0; n < 180; n++)
            begin
                if (ph == 2 && n == 90)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (exp_pending() != 0)
                        @(posedge clk);
                end
                it = rand_item();
                send_item(it);
            end
            drain_results();
        end

        if (errors == 0)
            $display("sample_time_sync_interpolator verification clean");
        else
            $display("sample_time_sync_interpolator verification failed");
        $finish;
    end

endmodule
`default_nettype wire
